FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MTR_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define MTR_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: src/mtr_pkg.sv
// ---------------------------------------------------------------------------
// mtr_pkg
// types, codes and constants of the matrix translate/rotate block
// ---------------------------------------------------------------------------
package mtr_pkg;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ROTATE    = 1'b1;

  localparam logic [7:0] AXIS_X_LO = 8'h78;
  localparam logic [7:0] AXIS_X_UP = 8'h58;
  localparam logic [7:0] AXIS_Y_LO = 8'h79;
  localparam logic [7:0] AXIS_Y_UP = 8'h59;
  localparam logic [7:0] AXIS_Z_LO = 8'h7A;
  localparam logic [7:0] AXIS_Z_UP = 8'h5A;

  localparam int CORDIC_STEPS = 16;
  localparam int TRIG_FRAC    = 30;
  localparam int TRIG_W       = 33;
  localparam int ACC_W        = 68;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cosv;
    logic signed [TRIG_W-1:0] sinv;
  } trig_t;

  function automatic logic signed [31:0] atan_deg(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:    v = 32'sd2949120;
      4'd1:    v = 32'sd1740967;
      4'd2:    v = 32'sd919879;
      4'd3:    v = 32'sd466945;
      4'd4:    v = 32'sd234379;
      4'd5:    v = 32'sd117304;
      4'd6:    v = 32'sd58666;
      4'd7:    v = 32'sd29335;
      4'd8:    v = 32'sd14668;
      4'd9:    v = 32'sd7334;
      4'd10:   v = 32'sd3667;
      4'd11:   v = 32'sd1833;
      4'd12:   v = 32'sd917;
      4'd13:   v = 32'sd458;
      4'd14:   v = 32'sd229;
      default: v = 32'sd115;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
    lo = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: src/mtr_if.sv
// ---------------------------------------------------------------------------
// mtr_if
// request and row result channels, valid/ready handshake
// ---------------------------------------------------------------------------
interface mtr_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  logic signed [31:0] angle_deg;
  logic [7:0]         axis_char;

  modport source (output valid, command, move_x, move_y, move_z, angle_deg, axis_char,
                  input ready);
  modport sink (input valid, command, move_x, move_y, move_z, angle_deg, axis_char,
                output ready);
endinterface

interface mtr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic               bad_axis;
  logic               last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, bad_axis, last_row,
                  input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, bad_axis, last_row,
                output ready);
endinterface

FILE: src/matrix_translate_rotate.sv
// ---------------------------------------------------------------------------
// matrix_translate_rotate
// 4x4 q-format transform matrix with translate and rotate requests
// ---------------------------------------------------------------------------
// One request at a time. The matrix lives in a 16-word RAM with one read and
// one write port and a single shared multiplier walks it column by column:
// each column is read, multiplied and then written back, once for a translate
// or twice for a rotate, and then each row is read and emitted. A rotate
// first runs the angle reduction (8 steps at 16 fraction bits) and the cordic.
// A rotate with an illegal axis skips straight to the row dump.
`include "assert_macros.svh"

module matrix_translate_rotate #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  mtr_in_if.sink    in_req,
  mtr_out_if.source out_row
);

  localparam int TW     = mtr_pkg::TRIG_W;
  localparam int AW     = mtr_pkg::ACC_W;
  localparam int PROD_W = TW + 32;
  localparam logic signed [31:0]     ONE    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_F = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0]   RND_T  = AW'(1) <<< (mtr_pkg::TRIG_FRAC - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_TRIG = 7'b000_0010,
    S_RD   = 7'b000_0100,
    S_MUL  = 7'b000_1000,
    S_WR   = 7'b001_0000,
    S_ERD  = 7'b010_0000,
    S_EOUT = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] col_r, col_nxt;
  logic [1:0] row_r, row_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic               rot_r, neg_r, bad_r;
  logic [1:0]         p_r, q_r;
  logic signed [31:0] mx_r, my_r, mz_r;
  logic signed [TW-1:0] c_r, s_r;
  logic signed [31:0] op_r [4];
  logic signed [AW-1:0] acc_p_r, acc_q_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [1:0]         orow_r;
  logic signed [31:0] ocol_r [4];
  logic               obad_r, olast_r;

  logic [31:0] mem [16];
  logic [15:0] vld_r;
  logic [31:0] mem_q;
  logic        hit_q;
  logic [3:0]  raddr_q;

  logic [3:0]         rd_addr, wr_addr;
  logic               mem_we, load_out, trig_start, trig_done;
  logic signed [31:0] wr_data, rd_data;
  mtr_pkg::trig_t     trig;

  logic               axis_ok, axis_neg;
  logic [1:0]         axis_p, axis_q;
  logic [1:0]         mj, aj;
  logic signed [TW-1:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [PROD_W-1:0] term_sh;
  logic signed [AW-1:0] term_tr, prod_ext, rnd_p, rnd_q;

  mtr_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (in_req.angle_deg),
    .done  (trig_done),
    .trig  (trig)
  );

  // axis decode
  always_comb begin
    axis_ok  = 1'b1;
    axis_neg = 1'b0;
    axis_p   = 2'd0;
    axis_q   = 2'd1;
    unique case (in_req.axis_char) inside
      mtr_pkg::AXIS_X_LO, mtr_pkg::AXIS_X_UP: begin
        axis_p = 2'd1;
        axis_q = 2'd2;
      end
      mtr_pkg::AXIS_Y_LO, mtr_pkg::AXIS_Y_UP: begin
        axis_q   = 2'd2;
        axis_neg = 1'b1;
      end
      mtr_pkg::AXIS_Z_LO, mtr_pkg::AXIS_Z_UP: ;
      default: axis_ok = 1'b0;
    endcase
  end

  assign rd_data = hit_q ? $signed(mem_q) : ((raddr_q[3:2] == raddr_q[1:0]) ? ONE : '0);

  assign mj = cnt_r[1:0];
  assign aj = 2'(cnt_r - 3'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mj)
      2'd0: begin
        mul_a = rot_r ? c_r : TW'(mx_r);
        mul_b = rot_r ? op_r[p_r] : op_r[0];
      end
      2'd1: begin
        mul_a = rot_r ? s_r : TW'(my_r);
        mul_b = rot_r ? op_r[q_r] : op_r[1];
      end
      2'd2: begin
        mul_a = rot_r ? c_r : TW'(mz_r);
        mul_b = rot_r ? op_r[q_r] : op_r[2];
      end
      default: begin
        mul_a = rot_r ? s_r : '0;
        mul_b = rot_r ? op_r[p_r] : '0;
      end
    endcase
  end

  assign term_sh  = (prod_r + RND_F) >>> FRAC_BITS;
  assign term_tr  = {{(AW-PROD_W){term_sh[PROD_W-1]}}, term_sh};
  assign prod_ext = {{(AW-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign rnd_p    = (acc_p_r + RND_T) >>> mtr_pkg::TRIG_FRAC;
  assign rnd_q    = (acc_q_r + RND_T) >>> mtr_pkg::TRIG_FRAC;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_row.ready;
    load_out      = 1'b0;
    trig_start    = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = {cnt_r[1:0], col_r};
    wr_addr       = {2'd3, col_r};
    wr_data       = mtr_pkg::sat32(acc_p_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          cnt_nxt = '0;
          col_nxt = '0;
          row_nxt = '0;
          if (in_req.command == mtr_pkg::CMD_ROTATE) begin
            if (axis_ok) begin
              trig_start = 1'b1;
              state_nxt  = S_TRIG;
            end else begin
              state_nxt = S_ERD;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_TRIG: if (trig_done) state_nxt = S_RD;
      S_RD: begin
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_MUL: begin
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_WR;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        if (rot_r) begin
          wr_addr = cnt_r[0] ? {q_r, col_r} : {p_r, col_r};
          wr_data = cnt_r[0] ? mtr_pkg::sat32(rnd_q) : mtr_pkg::sat32(rnd_p);
        end
        if (!rot_r || cnt_r[0]) begin
          cnt_nxt = '0;
          if (col_r == 2'd3) begin
            state_nxt = S_ERD;
          end else begin
            col_nxt   = col_r + 2'd1;
            state_nxt = S_RD;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_ERD: begin
        rd_addr = {row_r, cnt_r[1:0]};
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_EOUT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_EOUT: begin
        if (!out_valid_r || out_row.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (row_r == 2'd3) begin
            state_nxt = S_IDLE;
          end else begin
            row_nxt   = row_r + 2'd1;
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) vld_r[wr_addr] <= 1'b1;
    end
  end

  // matrix ram
  always_ff @(posedge clk) begin
    mem_q   <= mem[rd_addr];
    hit_q   <= vld_r[rd_addr];
    raddr_q <= rd_addr;
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_req.valid) begin
      rot_r <= in_req.command;
      mx_r  <= in_req.move_x;
      my_r  <= in_req.move_y;
      mz_r  <= in_req.move_z;
      p_r   <= axis_p;
      q_r   <= axis_q;
      neg_r <= axis_neg;
      bad_r <= (in_req.command == mtr_pkg::CMD_ROTATE) && !axis_ok;
    end
    if (state_r == S_TRIG && trig_done) begin
      c_r <= trig.cosv;
      s_r <= neg_r ? -trig.sinv : trig.sinv;
    end
    if ((state_r == S_RD || state_r == S_ERD) && cnt_r != '0) begin
      op_r[aj] <= rd_data;
    end
    if (state_r == S_RD && cnt_r == 3'd4) begin
      acc_p_r <= rot_r ? '0 : {{(AW-32){rd_data[31]}}, rd_data};
      acc_q_r <= '0;
    end
    if (state_r == S_MUL) begin
      if (cnt_r != 3'd4) prod_r <= mul_a * mul_b;
      if (cnt_r != '0) begin
        case (aj)
          2'd0, 2'd1: acc_p_r <= acc_p_r + (rot_r ? prod_ext : term_tr);
          2'd2: begin
            if (rot_r) acc_q_r <= acc_q_r + prod_ext;
            else       acc_p_r <= acc_p_r + term_tr;
          end
          default: if (rot_r) acc_q_r <= acc_q_r - prod_ext;
        endcase
      end
    end
    if (load_out) begin
      orow_r    <= row_r;
      ocol_r[0] <= op_r[0];
      ocol_r[1] <= op_r[1];
      ocol_r[2] <= op_r[2];
      ocol_r[3] <= op_r[3];
      obad_r    <= bad_r;
      olast_r   <= (row_r == 2'd3);
    end
  end

  assign in_req.ready      = (state_r == S_IDLE);
  assign out_row.valid     = out_valid_r;
  assign out_row.row_index = orow_r;
  assign out_row.col0      = ocol_r[0];
  assign out_row.col1      = ocol_r[1];
  assign out_row.col2      = ocol_r[2];
  assign out_row.col3      = ocol_r[3];
  assign out_row.bad_axis  = obad_r;
  assign out_row.last_row  = olast_r;

  `MTR_ASSERT_IMP(a_last_row3, clk, rst_n, out_row.valid && out_row.last_row, out_row.row_index == 2'd3)
  `MTR_ASSERT_IMP(a_wr_only_wr, clk, rst_n, mem_we, state_r == S_WR)
  `MTR_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_req.valid && in_req.ready, state_r != S_IDLE)

endmodule

FILE: src/mtr_sincos.sv
// ---------------------------------------------------------------------------
// mtr_sincos
// angle reduction and iterative cordic cosine/sine in degrees
// ---------------------------------------------------------------------------
module mtr_sincos #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  angle,
  output logic                done,
  output mtr_pkg::trig_t      trig
);

  localparam int REM_W = 41;
  localparam logic [REM_W-1:0] FULL  = REM_W'(360) << FRAC_BITS;
  localparam logic [REM_W-1:0] HALF  = REM_W'(180) << FRAC_BITS;
  localparam logic [REM_W-1:0] QUART = REM_W'(90) << FRAC_BITS;
  localparam int FULL_LOG  = $clog2(FULL);
  localparam int RED_STEPS = (FULL_LOG >= 33) ? 1 : 33 - FULL_LOG;
  localparam int K_W       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic signed [63:0] ZRND = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [7:0] {
    T_IDLE = 8'b0000_0001,
    T_RED  = 8'b0000_0010,
    T_FIX  = 8'b0000_0100,
    T_WRAP = 8'b0000_1000,
    T_FOLD = 8'b0001_0000,
    T_ZCV  = 8'b0010_0000,
    T_ITER = 8'b0100_0000,
    T_OUT  = 8'b1000_0000
  } tstate_t;

  tstate_t                          state_r, state_nxt;
  logic [K_W-1:0]                   k_r;
  logic [3:0]                       i_r;
  logic                             neg_r;
  logic                             flip_r;
  logic [REM_W-1:0]                 mag_r;
  logic signed [REM_W-1:0]          rem_r;
  logic signed [31:0]               z_r;
  logic signed [mtr_pkg::TRIG_W-1:0] x_r, y_r;
  logic                             done_r;
  mtr_pkg::trig_t                   trig_r;

  logic [31:0]                      abs_angle;
  logic [REM_W-1:0]                 sub_val;
  logic signed [63:0]               z_ext;
  logic signed [63:0]               z_sum;
  logic signed [mtr_pkg::TRIG_W-1:0] dx, dy;
  logic signed [31:0]               at;

  assign abs_angle = angle[31] ? 32'(-angle) : angle;
  assign sub_val   = FULL << k_r;
  assign z_ext     = {{(64-REM_W){rem_r[REM_W-1]}}, rem_r};
  assign z_sum     = (z_ext <<< 16) + ZRND;
  assign dx        = y_r >>> i_r;
  assign dy        = x_r >>> i_r;
  assign at        = mtr_pkg::atan_deg(i_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (start) state_nxt = T_RED;
      T_RED:  if (k_r == '0) state_nxt = T_FIX;
      T_FIX:  state_nxt = T_WRAP;
      T_WRAP: state_nxt = T_FOLD;
      T_FOLD: state_nxt = T_ZCV;
      T_ZCV:  state_nxt = T_ITER;
      T_ITER: if (i_r == 4'(mtr_pkg::CORDIC_STEPS - 1)) state_nxt = T_OUT;
      T_OUT:  state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == T_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      T_IDLE: begin
        neg_r <= angle[31];
        mag_r <= {{(REM_W-32){1'b0}}, abs_angle};
        k_r   <= K_W'(RED_STEPS - 1);
      end
      T_RED: begin
        if (mag_r >= sub_val) mag_r <= mag_r - sub_val;
        k_r <= k_r - 1'b1;
      end
      T_FIX: begin
        rem_r <= (neg_r && (mag_r != '0)) ? $signed(FULL - mag_r) : $signed(mag_r);
      end
      T_WRAP: begin
        if (rem_r > $signed(HALF)) rem_r <= rem_r - $signed(FULL);
      end
      T_FOLD: begin
        if (rem_r > $signed(QUART)) begin
          rem_r  <= rem_r - $signed(HALF);
          flip_r <= 1'b1;
        end else if (rem_r < -$signed(QUART)) begin
          rem_r  <= rem_r + $signed(HALF);
          flip_r <= 1'b1;
        end else begin
          flip_r <= 1'b0;
        end
      end
      T_ZCV: begin
        z_r <= 32'(z_sum >>> FRAC_BITS);
        x_r <= mtr_pkg::CORDIC_GAIN;
        y_r <= '0;
        i_r <= '0;
      end
      T_ITER: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
      end
      T_OUT: begin
        trig_r.cosv <= flip_r ? -x_r : x_r;
        trig_r.sinv <= flip_r ? -y_r : y_r;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign trig = trig_r;

endmodule
